// ===== src/pbd_pkg.sv =====
// Shared types and constants for the pulse beat detector.
// Used by pbd_div and pulse_beat_detector; no dependencies.
`timescale 1ns / 1ps

package pbd_pkg;

  // Default number of intervals kept for the BPM average.
  localparam int HISTORY_DEPTH_DEF = 10;

  // Configuration register reset values.
  localparam logic [9:0]  DEF_THRESHOLD  = 10'd530;
  localparam logic [9:0]  DEF_SEED_LEVEL = 10'd512;
  localparam logic [11:0] DEF_REFRACTORY = 12'd250;
  localparam logic [12:0] DEF_TIMEOUT    = 13'd2500;

  // Detector constants.
  localparam logic [15:0] BPM_NUMERATOR = 16'd60000;
  localparam logic [15:0] INTERVAL_SEED = 16'd600;
  // Settle window for the seed interval: (600 / 5) * 3.
  localparam logic [15:0] SETTLE_SEED   = 16'd360;
  // x / 5 as (x * 52429) >> 18, exact for every 16-bit x.
  localparam logic [15:0] SETTLE_MUL    = 16'd52429;
  localparam int          SETTLE_SHIFT  = 18;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_DEFAULT_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SEED_LEVEL        = 2'd1;
  localparam logic [1:0] REG_REFRACTORY_MS     = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_MS        = 2'd3;

  typedef struct packed {
    logic [9:0] sample;
    logic [7:0] elapsed_ms;
  } pbd_in_t;

  typedef struct packed {
    logic [7:0]  bpm;
    logic        beat;
    logic        pulse;
    logic [15:0] interval_ms;
  } pbd_out_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } pbd_div_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_EVAL,
    ST_MEAN,
    ST_BPM,
    ST_DONE
  } pbd_state_t;

endpackage

// ===== src/pbd_div.sv =====
// Restoring divider, one quotient bit per cycle, used by the sequencer.
// Depends on pbd_pkg for the status struct.
`timescale 1ns / 1ps

module pbd_div import pbd_pkg::*; #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output pbd_div_st_t  status,
  output logic [W-1:0] quo
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     den_r;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift in one numerator bit, subtract when it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      if (diff[W]) begin
        rem_r <= rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end else begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quo         = quo_r;

endmodule

// ===== src/pulse_beat_detector.sv =====
// Pulse beat detector: peak/trough tracking, adaptive threshold, BPM from
// the mean of the last HISTORY_DEPTH inter-beat intervals.
// Depends on pbd_pkg and pbd_div.
// An accepted sample passes ST_GAP, ST_EVAL and ST_DONE, and the result
// reaches the output register as ST_DONE returns to ST_IDLE; a counted beat
// also passes ST_MEAN and ST_BPM, where the divider forms 60000 / mean, and a
// counted beat that also times out passes ST_MEAN but skips the division. The
// input stalls until the result is in the output register, so a new sample is
// taken only after that, and ST_DONE also waits while the result channel holds
// back the previous result. Reset is synchronous and sets the control state to
// its reset values; the payload registers and the interval history have no reset.
`timescale 1ns / 1ps

module pulse_beat_detector import pbd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  pbd_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output pbd_out_t    out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Sum of the history: D * 65535 must fit.
  localparam int SUM_W = 16 + $clog2(HISTORY_DEPTH);
  // The divider only forms 60000 / mean, both 16 bits.
  localparam int DIV_W = 16;
  // Mean as sum * ceil(2^MEAN_SH / D) >> MEAN_SH, exact for every SUM_W-bit sum.
  localparam int MEAN_SH = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int PROD_W  = SUM_W + MEAN_SH + 1;
  localparam logic [63:0] MEAN_MUL_W =
    ((64'd1 << MEAN_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [MEAN_SH:0] MEAN_MUL = MEAN_MUL_W[MEAN_SH:0];

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [9:0]  def_thr_r;
  logic [9:0]  seed_lvl_r;
  logic [11:0] refr_r;
  logic [12:0] tmo_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_thr_r  <= DEF_THRESHOLD;
      seed_lvl_r <= DEF_SEED_LEVEL;
      refr_r     <= DEF_REFRACTORY;
      tmo_r      <= DEF_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DEFAULT_THRESHOLD: def_thr_r  <= pwdata[9:0];
        REG_SEED_LEVEL:        seed_lvl_r <= pwdata[9:0];
        REG_REFRACTORY_MS:     refr_r     <= pwdata[11:0];
        REG_TIMEOUT_MS:        tmo_r      <= pwdata[12:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEFAULT_THRESHOLD: prdata = {22'd0, def_thr_r};
      REG_SEED_LEVEL:        prdata = {22'd0, seed_lvl_r};
      REG_REFRACTORY_MS:     prdata = {20'd0, refr_r};
      REG_TIMEOUT_MS:        prdata = {19'd0, tmo_r};
    endcase
  end

  // ---------------------------------------------------------------------
  // Detector state
  // ---------------------------------------------------------------------
  pbd_state_t  state_r,      state_nxt;
  logic [31:0] time_r,       time_nxt;
  logic [31:0] last_beat_r,  last_beat_nxt;
  logic [31:0] gap_r,        gap_nxt;
  logic [9:0]  sample_r,     sample_nxt;
  logic [9:0]  peak_r,       peak_nxt;
  logic [9:0]  trough_r,     trough_nxt;
  logic [9:0]  thr_r,        thr_nxt;
  logic [15:0] interval_r,   interval_nxt;
  logic [15:0] settle_r,     settle_nxt;
  logic        in_pulse_r,   in_pulse_nxt;
  logic        first_r,      first_nxt;
  logic        second_r,     second_nxt;
  logic [7:0]  bpm_r,        bpm_nxt;
  logic        beat_r,       beat_nxt;
  logic        tmo_hit_r,    tmo_hit_nxt;
  logic [SUM_W-1:0] sum_r,   sum_nxt;
  logic        out_valid_r,  out_valid_nxt;
  pbd_out_t    out_data_r,   out_data_nxt;

  // Interval history: a shift line, oldest entry at index 0.
  logic [15:0] hist_r [HISTORY_DEPTH];
  logic        hist_seed;
  logic        hist_push;

  // BPM divider
  logic             div_start;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W-1:0] div_quo;
  pbd_div_st_t      div_st;

  pbd_div #(
    .W (DIV_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .status (div_st),
    .quo    (div_quo)
  );

  // ---------------------------------------------------------------------
  // Per-sample evaluation, valid in ST_EVAL
  // ---------------------------------------------------------------------
  logic             s_lt_thr;
  logic             s_gt_thr;
  logic             gap_gt_settle;
  logic [9:0]       peak_mid;
  logic [9:0]       trough_mid;
  logic             beat_det;
  logic             pulse_end;
  logic             tmo_det;
  logic [15:0]      li_new;
  logic [SUM_W-1:0] sum_seed;
  logic [SUM_W-1:0] sum_roll;
  logic signed [11:0] amp_s;
  logic signed [11:0] half_s;
  logic signed [11:0] mid_s;
  logic [9:0]       mid_thr;
  // Settle window (interval / 5) * 3, formed in ST_GAP
  logic [31:0]      settle_prod;
  logic [13:0]      settle_q;
  logic [15:0]      settle_calc;
  // Mean interval, formed in ST_MEAN
  logic [PROD_W-1:0] mean_prod;
  logic [15:0]      mean_w;

  assign s_lt_thr      = sample_r < thr_r;
  assign s_gt_thr      = sample_r > thr_r;
  assign gap_gt_settle = gap_r > {16'd0, settle_r};

  assign trough_mid = (s_lt_thr && gap_gt_settle && sample_r < trough_r) ? sample_r : trough_r;
  assign peak_mid   = (s_gt_thr && sample_r > peak_r) ? sample_r : peak_r;

  assign beat_det = (gap_r > {20'd0, refr_r}) && s_gt_thr && !in_pulse_r && gap_gt_settle;
  // A beat means the sample is above threshold, so it never ends a pulse too.
  assign pulse_end = s_lt_thr && in_pulse_r;
  // The first beat ends the step before the timeout check.
  assign tmo_det   = (gap_r > {19'd0, tmo_r}) && !(beat_det && first_r);

  // Saturate the measured interval to 16 bits.
  assign li_new   = (|gap_r[31:16]) ? 16'hFFFF : gap_r[15:0];
  assign sum_seed = SUM_W'(li_new) * SUM_W'(HISTORY_DEPTH);
  assign sum_roll = sum_r - SUM_W'(hist_r[0]) + SUM_W'(li_new);

  // New threshold: trough + (peak - trough) / 2, truncating toward zero.
  assign amp_s  = $signed({2'b00, peak_mid}) - $signed({2'b00, trough_mid});
  assign half_s = (amp_s + $signed({11'd0, amp_s[11]})) >>> 1;
  assign mid_s  = half_s + $signed({2'b00, trough_mid});
  assign mid_thr = mid_s[11] ? 10'd0 : ((mid_s > 12'sd1023) ? 10'd1023 : mid_s[9:0]);

  // Reciprocal multiplications replace the constant divisions.
  assign settle_prod = {16'd0, interval_r} * {16'd0, SETTLE_MUL};
  assign settle_q    = settle_prod[SETTLE_SHIFT +: 14];
  assign settle_calc = {1'b0, settle_q, 1'b0} + {2'b00, settle_q};

  assign mean_prod = PROD_W'(sum_r) * PROD_W'(MEAN_MUL);
  assign mean_w    = mean_prod[MEAN_SH +: 16];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    last_beat_nxt = last_beat_r;
    gap_nxt       = gap_r;
    sample_nxt    = sample_r;
    peak_nxt      = peak_r;
    trough_nxt    = trough_r;
    thr_nxt       = thr_r;
    interval_nxt  = interval_r;
    settle_nxt    = settle_r;
    in_pulse_nxt  = in_pulse_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    bpm_nxt       = bpm_r;
    beat_nxt      = beat_r;
    tmo_hit_nxt   = tmo_hit_r;
    sum_nxt       = sum_r;
    out_data_nxt  = out_data_r;
    hist_seed     = 1'b0;
    hist_push     = 1'b0;
    div_start     = 1'b0;
    div_num       = BPM_NUMERATOR;
    div_den       = mean_w;

    // Drop the result once the downstream side takes it.
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        // Advance the time count as the sample is taken.
        if (in_valid) begin
          time_nxt   = time_r + 32'(in_data.elapsed_ms);
          sample_nxt = in_data.sample;
          state_nxt  = ST_GAP;
        end
      end

      ST_GAP: begin
        // The settle window comes from the interval before this sample.
        gap_nxt    = time_r - last_beat_r;
        settle_nxt = settle_calc;
        state_nxt  = ST_EVAL;
      end

      ST_EVAL: begin
        beat_nxt    = 1'b0;
        peak_nxt    = peak_mid;
        trough_nxt  = trough_mid;
        tmo_hit_nxt = tmo_det;
        state_nxt   = ST_DONE;

        if (beat_det) begin
          in_pulse_nxt  = 1'b1;
          interval_nxt  = li_new;
          last_beat_nxt = time_r;
          if (first_r) begin
            // Discard the first beat; only mark it.
            first_nxt  = 1'b0;
            second_nxt = 1'b1;
          end else begin
            second_nxt = 1'b0;
            beat_nxt   = 1'b1;
            if (second_r) begin
              hist_seed = 1'b1;
              sum_nxt   = sum_seed;
            end else begin
              hist_push = 1'b1;
              sum_nxt   = sum_roll;
            end
            state_nxt = ST_MEAN;
          end
        end

        if (pulse_end) begin
          in_pulse_nxt = 1'b0;
          thr_nxt      = mid_thr;
          peak_nxt     = mid_thr;
          trough_nxt   = mid_thr;
        end

        if (tmo_det) begin
          thr_nxt       = def_thr_r;
          peak_nxt      = seed_lvl_r;
          trough_nxt    = seed_lvl_r;
          last_beat_nxt = time_r;
          first_nxt     = 1'b1;
          second_nxt    = 1'b0;
          bpm_nxt       = 8'd0;
        end
      end

      ST_MEAN: begin
        if (tmo_hit_r) begin
          // Timeout already cleared bpm; skip the BPM division.
          state_nxt = ST_DONE;
        end else if (mean_w == '0) begin
          bpm_nxt   = 8'd255;
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_BPM;
        end
      end

      ST_BPM: begin
        if (div_st.done) begin
          bpm_nxt   = (div_quo > DIV_W'(255)) ? 8'd255 : div_quo[7:0];
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.bpm         = bpm_r;
          out_data_nxt.beat        = beat_r;
          out_data_nxt.pulse       = in_pulse_r;
          out_data_nxt.interval_ms = interval_r;
          state_nxt                = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      last_beat_r <= '0;
      peak_r      <= DEF_SEED_LEVEL;
      trough_r    <= DEF_SEED_LEVEL;
      thr_r       <= DEF_THRESHOLD;
      interval_r  <= INTERVAL_SEED;
      settle_r    <= SETTLE_SEED;
      in_pulse_r  <= 1'b0;
      first_r     <= 1'b1;
      second_r    <= 1'b0;
      bpm_r       <= '0;
      beat_r      <= 1'b0;
      tmo_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      last_beat_r <= last_beat_nxt;
      peak_r      <= peak_nxt;
      trough_r    <= trough_nxt;
      thr_r       <= thr_nxt;
      interval_r  <= interval_nxt;
      settle_r    <= settle_nxt;
      in_pulse_r  <= in_pulse_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      bpm_r       <= bpm_nxt;
      beat_r      <= beat_nxt;
      tmo_hit_r   <= tmo_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    gap_r      <= gap_nxt;
    sample_r   <= sample_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  // History: fill on the seeding beat, otherwise shift in the newest interval.
  always_ff @(posedge clk) begin
    if (hist_seed) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= li_new;
      end
    end else if (hist_push) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[HISTORY_DEPTH-1] <= li_new;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the done step");

  a_beat_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.beat) |-> out_data_r.pulse)
    else $error("counted beat reported outside a pulse");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r == ST_BPM))
    else $error("divider busy while the sequencer does not wait on it");

endmodule
